// ===== sv/dc_block_envelope_limiter_assert.svh =====
// Assertion macros for the DC blocker / envelope limiter checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef DC_BLOCK_ENVELOPE_LIMITER_ASSERT_SVH
`define DC_BLOCK_ENVELOPE_LIMITER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DCEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DCEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dcel_pkg.sv =====
// Shared types, constants and microcode ROM for the DC blocker / envelope limiter.
// No dependencies.
`timescale 1ns / 1ps

package dcel_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 24;

  localparam int INT_FRAC  = 28;            // fraction bits of the internal levels
  localparam int LVL_W     = 32;            // DC level, signed Q3.28
  localparam int MAG_W     = LVL_W + 1;     // magnitudes and envelope, unsigned Q5.28
  localparam int K_FRAC    = 24;
  localparam int DV_W      = MAG_W + K_FRAC; // divider numerator / denominator
  localparam int VOL_W     = 16;
  localparam int VOL_FRAC  = 14;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 4;

  localparam logic [K_FRAC-1:0] K_SIX_TENTHS = 24'd10066330;
  localparam logic [MAG_W-1:0]  ENV_ONE      = MAG_W'(1) << INT_FRAC;

  localparam int DC_COEF_RST      = 175;
  localparam int ATTACK_COEF_RST  = 69760;
  localparam int RELEASE_COEF_RST = 1747;
  localparam int VOLUME_RST       = 16384;

  typedef enum logic [1:0] {
    REG_DC_COEF      = 2'd0,
    REG_ATTACK_COEF  = 2'd1,
    REG_RELEASE_COEF = 2'd2,
    REG_VOLUME       = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_IDLE,      // ready for a transaction, latch the sample
    OP_DC_DIFF,   // load multiplier with |x - dc|, dc_coef
    OP_MUL,       // product register <= a * b
    OP_DC_UPD,    // dc += signed step
    OP_MAG,       // sign and magnitude of x - dc
    OP_ENV_DIFF,  // load multiplier with |mag - env|, attack or release
    OP_ENV_UPD,   // env += signed step, floor at 1.0
    OP_NUM,       // load multiplier with mag, 0.6
    OP_DIV_INIT,  // load remainder, clamp check
    OP_DIV_STEP,  // one restoring division step
    OP_VOL,       // load multiplier with quotient, volume
    OP_EMIT,      // saturate, sign, write output register
    OP_NOP
  } uop_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_NO_TXN,    // no input transaction this cycle
    JC_GE,        // numerator >= denominator
    JC_MORE,      // division steps left
    JC_BUSY       // output register still occupied
  } jcond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] upc_t;

  localparam upc_t PC_IDLE     = 4'd0;
  localparam upc_t PC_DC_DIFF  = 4'd1;
  localparam upc_t PC_DC_MUL   = 4'd2;
  localparam upc_t PC_DC_UPD   = 4'd3;
  localparam upc_t PC_MAG      = 4'd4;
  localparam upc_t PC_ENV_DIFF = 4'd5;
  localparam upc_t PC_ENV_MUL  = 4'd6;
  localparam upc_t PC_ENV_UPD  = 4'd7;
  localparam upc_t PC_NUM      = 4'd8;
  localparam upc_t PC_NUM_MUL  = 4'd9;
  localparam upc_t PC_DIV_INIT = 4'd10;
  localparam upc_t PC_DIV_STEP = 4'd11;
  localparam upc_t PC_VOL      = 4'd12;
  localparam upc_t PC_VOL_MUL  = 4'd13;
  localparam upc_t PC_EMIT     = 4'd14;

  typedef struct packed {
    uop_t   op;
    jcond_t cond;
    upc_t   jmp;   // taken when cond holds
    upc_t   seq;   // fall-through
  } uword_t;

  typedef struct packed {
    logic in_txn;
    logic ge;
    logic more;
    logic out_busy;
  } dp_stat_t;

  function automatic uword_t urom(input upc_t pc);
    uword_t w;
    case (pc)
      PC_IDLE:     w = '{op: OP_IDLE,     cond: JC_NO_TXN, jmp: PC_IDLE,     seq: PC_DC_DIFF};
      PC_DC_DIFF:  w = '{op: OP_DC_DIFF,  cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_DC_MUL};
      PC_DC_MUL:   w = '{op: OP_MUL,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_DC_UPD};
      PC_DC_UPD:   w = '{op: OP_DC_UPD,   cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_MAG};
      PC_MAG:      w = '{op: OP_MAG,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_ENV_DIFF};
      PC_ENV_DIFF: w = '{op: OP_ENV_DIFF, cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_ENV_MUL};
      PC_ENV_MUL:  w = '{op: OP_MUL,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_ENV_UPD};
      PC_ENV_UPD:  w = '{op: OP_ENV_UPD,  cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_NUM};
      PC_NUM:      w = '{op: OP_NUM,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_NUM_MUL};
      PC_NUM_MUL:  w = '{op: OP_MUL,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_DIV_INIT};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: JC_GE,     jmp: PC_VOL,      seq: PC_DIV_STEP};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: JC_MORE,   jmp: PC_DIV_STEP, seq: PC_VOL};
      PC_VOL:      w = '{op: OP_VOL,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_VOL_MUL};
      PC_VOL_MUL:  w = '{op: OP_MUL,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_EMIT};
      PC_EMIT:     w = '{op: OP_EMIT,     cond: JC_BUSY,   jmp: PC_EMIT,     seq: PC_IDLE};
      default:     w = '{op: OP_NOP,      cond: JC_NEVER,  jmp: PC_IDLE,     seq: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/dc_block_envelope_limiter.sv =====
// DC blocker with envelope-following limiter: one signed Q3.20 sample per input
// transaction, one limited sample per output transaction. Each sample has a
// one-pole DC estimate removed, its magnitude drives an attack/release envelope
// (floored at 1.0), and the output is 0.6*x/envelope clamped to +/-1 and scaled
// by volume (Q2.14). Samples are processed one at a time by a microcoded
// sequencer that steps a single shared multiplier and a bit-serial restoring
// divider, which yields one quotient bit per cycle and is skipped when the
// quotient clamps to full scale. A finished sample waits in the output
// register; the next sample is taken meanwhile and only its final step stalls
// if the previous result has not been taken. Registers (APB, 4-byte stride):
// 0 dc_coef, 1 attack_coef, 2 release_coef, 3 volume; write only while idle.
// Depends on dcel_pkg, dcel_regs, dcel_seq, dcel_dp.
`timescale 1ns / 1ps

module dc_block_envelope_limiter #(
  parameter int SAMPLE_WIDTH = dcel_pkg::SAMPLE_WIDTH_DEF,  // 16..32
  parameter int COEF_WIDTH   = dcel_pkg::COEF_WIDTH_DEF     // 16..32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input sample channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample_in,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   out_sample_out,
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dcel_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [dcel_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [dcel_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  logic [COEF_WIDTH-1:0]      dc_coef, attack_coef, release_coef;
  logic [dcel_pkg::VOL_W-1:0] volume;
  dcel_pkg::uop_t             op;
  dcel_pkg::dp_stat_t         stat;

  // coefficient and gain registers
  dcel_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .dc_coef      (dc_coef),
    .attack_coef  (attack_coef),
    .release_coef (release_coef),
    .volume       (volume)
  );

  // step counter + microcode ROM; jumps on input transaction, clamp,
  // divider count and output-register occupancy
  dcel_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  // levels, shared multiplier, divider and output register
  dcel_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .stat           (stat),
    .dc_coef        (dc_coef),
    .attack_coef    (attack_coef),
    .release_coef   (release_coef),
    .volume         (volume),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

endmodule

// ===== sv/dcel_regs.sv =====
// APB-style configuration registers: DC, attack and release coefficients, volume.
// Depends on dcel_pkg.
`timescale 1ns / 1ps

module dcel_regs #(
  parameter int COEF_WIDTH = dcel_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dcel_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [dcel_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [dcel_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output logic [COEF_WIDTH-1:0]         dc_coef,
  output logic [COEF_WIDTH-1:0]         attack_coef,
  output logic [COEF_WIDTH-1:0]         release_coef,
  output logic [dcel_pkg::VOL_W-1:0]    volume
);

  logic [COEF_WIDTH-1:0]      dc_coef_r, attack_coef_r, release_coef_r;
  logic [dcel_pkg::VOL_W-1:0] volume_r;
  dcel_pkg::reg_idx_t         idx;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = dcel_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_coef_r      <= COEF_WIDTH'(dcel_pkg::DC_COEF_RST);
      attack_coef_r  <= COEF_WIDTH'(dcel_pkg::ATTACK_COEF_RST);
      release_coef_r <= COEF_WIDTH'(dcel_pkg::RELEASE_COEF_RST);
      volume_r       <= dcel_pkg::VOL_W'(dcel_pkg::VOLUME_RST);
    end else if (wr_en) begin
      case (idx)
        dcel_pkg::REG_DC_COEF:      dc_coef_r      <= cfg_pwdata[COEF_WIDTH-1:0];
        dcel_pkg::REG_ATTACK_COEF:  attack_coef_r  <= cfg_pwdata[COEF_WIDTH-1:0];
        dcel_pkg::REG_RELEASE_COEF: release_coef_r <= cfg_pwdata[COEF_WIDTH-1:0];
        dcel_pkg::REG_VOLUME:       volume_r       <= cfg_pwdata[dcel_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dcel_pkg::REG_DC_COEF:      cfg_prdata = dcel_pkg::DATA_W'(dc_coef_r);
      dcel_pkg::REG_ATTACK_COEF:  cfg_prdata = dcel_pkg::DATA_W'(attack_coef_r);
      dcel_pkg::REG_RELEASE_COEF: cfg_prdata = dcel_pkg::DATA_W'(release_coef_r);
      dcel_pkg::REG_VOLUME:       cfg_prdata = dcel_pkg::DATA_W'(volume_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  assign dc_coef      = dc_coef_r;
  assign attack_coef  = attack_coef_r;
  assign release_coef = release_coef_r;
  assign volume       = volume_r;

endmodule

// ===== sv/dcel_seq.sv =====
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on dcel_pkg (control word layout and ROM).
`timescale 1ns / 1ps

module dcel_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  dcel_pkg::dp_stat_t stat,
  output dcel_pkg::uop_t     op
);

  dcel_pkg::upc_t   pc_r, pc_nxt;
  dcel_pkg::uword_t uw;
  logic             take;

  always_comb begin
    uw = dcel_pkg::urom(pc_r);
    case (uw.cond)
      dcel_pkg::JC_NO_TXN: take = ~stat.in_txn;
      dcel_pkg::JC_GE:     take = stat.ge;
      dcel_pkg::JC_MORE:   take = stat.more;
      dcel_pkg::JC_BUSY:   take = stat.out_busy;
      default:             take = 1'b0;
    endcase
    pc_nxt = take ? uw.jmp : uw.seq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dcel_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = uw.op;

endmodule

// ===== sv/dcel_dp.sv =====
// Datapath: DC and envelope levels, shared multiplier, restoring divider, output register.
// Depends on dcel_pkg; driven one micro-op per cycle by dcel_seq.
`timescale 1ns / 1ps

module dcel_dp #(
  parameter int SAMPLE_WIDTH = dcel_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = dcel_pkg::COEF_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dcel_pkg::uop_t                    op,
  output dcel_pkg::dp_stat_t                stat,
  input  logic [COEF_WIDTH-1:0]             dc_coef,
  input  logic [COEF_WIDTH-1:0]             attack_coef,
  input  logic [COEF_WIDTH-1:0]             release_coef,
  input  logic [dcel_pkg::VOL_W-1:0]        volume,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_out
);

  localparam int LVL_W  = dcel_pkg::LVL_W;
  localparam int MAG_W  = dcel_pkg::MAG_W;
  localparam int DV_W   = dcel_pkg::DV_W;
  localparam int GUARD  = LVL_W - SAMPLE_WIDTH;
  localparam int SF     = SAMPLE_WIDTH - 4;
  localparam int MB_W   = (COEF_WIDTH > dcel_pkg::K_FRAC) ? COEF_WIDTH : dcel_pkg::K_FRAC;
  localparam int PR_W   = MAG_W + MB_W;
  localparam int CNT_W  = $clog2(SF + 1);

  localparam logic [SF:0]             Q_ONE    = {1'b1, {SF{1'b0}}};
  localparam logic [CNT_W-1:0]        CNT_INIT = CNT_W'(SF);
  localparam logic [SAMPLE_WIDTH-1:0] LIM_POS  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] LIM_NEG  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [LVL_W-1:0]        xi_r, xi_nxt;
  logic [LVL_W-1:0]        dc_r, dc_nxt;
  logic [MAG_W-1:0]        env_r, env_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [MAG_W-1:0]        ma_r, ma_nxt;
  logic [MB_W-1:0]         mb_r, mb_nxt;
  logic                    sgn_r, sgn_nxt;
  logic [PR_W-1:0]         prod_r, prod_nxt;
  logic [DV_W-1:0]         rem_r, rem_nxt;
  logic [SF:0]             q_r, q_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [LVL_W-1:0]        xi_in;
  logic [MAG_W-1:0]        dif, dif_neg, dif_abs;
  logic [MAG_W:0]          ed, ed_neg;
  logic [MAG_W-1:0]        ed_abs;
  logic [MAG_W-1:0]        step;
  logic [LVL_W+1:0]        dc_ext, step_ext, dc_sum;
  logic [MAG_W:0]          env_sum;
  logic [DV_W-1:0]         num, den;
  logic [DV_W:0]           r2, r2_sub;
  logic                    r2_ge;
  logic [SAMPLE_WIDTH-1:0] y, lim, y_sat, y_out;
  logic                    out_busy;

  // sample into Q3.28
  assign xi_in = LVL_W'(in_sample_in) << GUARD;

  // x - dc, shared by the DC update and the magnitude step
  assign dif     = {xi_r[LVL_W-1], xi_r} - {dc_r[LVL_W-1], dc_r};
  assign dif_neg = ~dif + 1'b1;
  assign dif_abs = dif[MAG_W-1] ? dif_neg : dif;

  assign ed     = {1'b0, mag_r} - {1'b0, env_r};
  assign ed_neg = ~ed + 1'b1;
  assign ed_abs = ed[MAG_W] ? ed_neg[MAG_W-1:0] : ed[MAG_W-1:0];

  // one-pole step magnitude, truncated
  assign step     = prod_r[COEF_WIDTH +: MAG_W];
  assign dc_ext   = {{2{dc_r[LVL_W-1]}}, dc_r};
  assign step_ext = {1'b0, step};
  assign dc_sum   = sgn_r ? (dc_ext - step_ext) : (dc_ext + step_ext);
  assign env_sum  = sgn_r ? ({1'b0, env_r} - {1'b0, step}) : ({1'b0, env_r} + {1'b0, step});

  assign num    = prod_r[DV_W-1:0];
  assign den    = {env_r, {dcel_pkg::K_FRAC{1'b0}}};
  assign r2     = {rem_r, 1'b0};
  assign r2_sub = r2 - {1'b0, den};
  assign r2_ge  = r2 >= {1'b0, den};

  assign y     = prod_r[dcel_pkg::VOL_FRAC +: SAMPLE_WIDTH];
  assign lim   = neg_r ? LIM_NEG : LIM_POS;
  assign y_sat = (y > lim) ? lim : y;
  assign y_out = neg_r ? (~y_sat + 1'b1) : y_sat;

  assign in_ready = (op == dcel_pkg::OP_IDLE);
  assign out_busy = out_valid_r & ~out_ready;

  assign stat.in_txn   = in_valid & in_ready;
  assign stat.ge       = num >= den;
  assign stat.more     = cnt_r != CNT_W'(1);
  assign stat.out_busy = out_busy;

  always_comb begin
    xi_nxt        = xi_r;
    dc_nxt        = dc_r;
    env_nxt       = env_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    sgn_nxt       = sgn_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (op)
      dcel_pkg::OP_IDLE: begin
        xi_nxt = xi_in;
      end
      dcel_pkg::OP_DC_DIFF: begin
        ma_nxt  = dif_abs;
        sgn_nxt = dif[MAG_W-1];
        mb_nxt  = MB_W'(dc_coef);
      end
      dcel_pkg::OP_MUL: begin
        prod_nxt = ma_r * mb_r;
      end
      dcel_pkg::OP_DC_UPD: begin
        dc_nxt = dc_sum[LVL_W-1:0];
      end
      dcel_pkg::OP_MAG: begin
        mag_nxt = dif_abs;
        neg_nxt = dif[MAG_W-1];
      end
      dcel_pkg::OP_ENV_DIFF: begin
        ma_nxt  = ed_abs;
        sgn_nxt = ed[MAG_W];
        mb_nxt  = (mag_r > env_r) ? MB_W'(attack_coef) : MB_W'(release_coef);
      end
      dcel_pkg::OP_ENV_UPD: begin
        env_nxt = (env_sum < {1'b0, dcel_pkg::ENV_ONE}) ? dcel_pkg::ENV_ONE
                                                        : env_sum[MAG_W-1:0];
      end
      dcel_pkg::OP_NUM: begin
        ma_nxt = mag_r;
        mb_nxt = MB_W'(dcel_pkg::K_SIX_TENTHS);
      end
      dcel_pkg::OP_DIV_INIT: begin
        rem_nxt = num;
        q_nxt   = stat.ge ? Q_ONE : '0;
        cnt_nxt = CNT_INIT;
      end
      dcel_pkg::OP_DIV_STEP: begin
        rem_nxt = r2_ge ? r2_sub[DV_W-1:0] : r2[DV_W-1:0];
        q_nxt   = {q_r[SF-1:0], r2_ge};
        cnt_nxt = cnt_r - 1'b1;
      end
      dcel_pkg::OP_VOL: begin
        ma_nxt = MAG_W'(q_r);
        mb_nxt = MB_W'(volume);
      end
      dcel_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_data_nxt  = y_out;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r        <= '0;
      env_r       <= dcel_pkg::ENV_ONE;
      out_valid_r <= 1'b0;
    end else begin
      dc_r        <= dc_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xi_r       <= xi_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    sgn_r      <= sgn_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule

// ===== sv/dcel_checker.sv =====
// Port-level checker for dc_block_envelope_limiter, attached by bind.
// Depends on dcel_pkg and dc_block_envelope_limiter_assert.svh.
`timescale 1ns / 1ps
`include "dc_block_envelope_limiter_assert.svh"

module dcel_checker #(
  parameter int SAMPLE_WIDTH = dcel_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample_out
);

  // a stalled result stays put
  `DCEL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_out), "result changed while stalled")

  // an accepted sample keeps the input closed for at least the short path
  `DCEL_ASSERT_NXT(a_busy_after_txn, in_valid && in_ready, !in_ready ##12 !in_ready, "input reopened too early")

  // a new result appears exactly as the sequencer returns to idle
  `DCEL_ASSERT_IMP(a_result_at_idle, $rose(out_valid), in_ready, "result without return to idle")

  // no result while the input is open and nothing was pending
  `DCEL_ASSERT_NXT(a_no_spurious, !out_valid && in_ready && !in_valid, !out_valid, "result without a transaction")

endmodule

bind dc_block_envelope_limiter dcel_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dcel_checker (.*);
